FILE: src/gtg_pkg.sv
// ---------------------------------------------------------------------------
// gtg_pkg
// Shared constants, types and tables for the go-to-goal drive controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gtg_pkg;

  // Fixed-point format and iteration counts
  localparam int FRAC_BITS    = 12;
  localparam int CORDIC_STEPS = 16;
  localparam int ANG_FRAC     = 30;
  localparam int VEC_SHIFT    = 20;
  localparam int ANG_SHIFT    = ANG_FRAC - FRAC_BITS;

  // Field widths
  localparam int POS_W   = 16;
  localparam int HEAD_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int TOL_W   = 17;
  localparam int DIST_W  = 17;
  localparam int LIN_W   = 20;
  localparam int ANG_W   = 18;
  localparam int OFS_W   = POS_W + 1;
  localparam int SQ_W    = 2 * DIST_W;
  localparam int IN_W    = 2 * POS_W + HEAD_W;
  localparam int OUT_W   = LIN_W + ANG_W + DIST_W + 1;

  // CORDIC datapath widths
  localparam int XW      = OFS_W + VEC_SHIFT + 3;
  localparam int ZW      = 35;
  localparam int BEAR_W  = FRAC_BITS + 3;
  localparam int ERR_W   = ((BEAR_W > HEAD_W) ? BEAR_W : HEAD_W) + 1;
  localparam int LINP_W  = GAIN_W + DIST_W;
  localparam int ANGP_W  = GAIN_W + 1 + ERR_W;

  localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;

  // atan(2^-i) in Q.30
  localparam logic signed [ZW-1:0] ATAN_TAB [24] = '{
    35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
    35'sd67021687,  35'sd33543516,  35'sd16775851,  35'sd8388437,
    35'sd4194283,   35'sd2097149,   35'sd1048576,   35'sd524288,
    35'sd262144,    35'sd131072,    35'sd65536,     35'sd32768,
    35'sd16384,     35'sd8192,      35'sd4096,      35'sd2048,
    35'sd1024,      35'sd512,       35'sd256,       35'sd128
  };

  // Output limits
  localparam logic [LIN_W-1:0]        LIN_MAX = '1;
  localparam logic signed [ANG_W-1:0] ANG_MAX = {1'b0, {(ANG_W-1){1'b1}}};
  localparam logic signed [ANG_W-1:0] ANG_MIN = {1'b1, {(ANG_W-1){1'b0}}};

  // Pipeline stage map
  localparam int CORDIC_PRE   = 1;
  localparam int CORDIC_FIRST = CORDIC_PRE + 1;
  localparam int CORDIC_LAST  = CORDIC_FIRST + CORDIC_STEPS - 1;
  localparam int SQRT_FIRST   = 3;
  localparam int SQRT_LAST    = SQRT_FIRST + DIST_W - 1;
  localparam int CORE_LAST    = (CORDIC_LAST > SQRT_LAST) ? CORDIC_LAST : SQRT_LAST;
  localparam int DRV_ROUND    = CORE_LAST + 1;
  localparam int DRV_ERR      = CORE_LAST + 2;
  localparam int DRV_MUL      = CORE_LAST + 3;
  localparam int OUT_STAGE    = CORE_LAST + 4;
  localparam int N_STAGES     = OUT_STAGE + 1;

  typedef logic [N_STAGES-1:0] stage_en_t;

  // Configuration registers
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = TOL_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GOAL_X       = 3'd0,
    REG_GOAL_Y       = 3'd1,
    REG_ARRIVE_TOL   = 3'd2,
    REG_KP           = 3'd3,
    REG_HEADING_GAIN = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [POS_W-1:0]  goal_x;
    logic [POS_W-1:0]  goal_y;
    logic [TOL_W-1:0]  arrive_tolerance;
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] heading_gain;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    goal_x:           16'd4096,
    goal_y:           16'd4096,
    arrive_tolerance: 17'd4096,
    kp:               16'd4096,
    heading_gain:     16'd16384
  };

endpackage

`default_nettype wire

FILE: src/gtg_cordic.sv
// ---------------------------------------------------------------------------
// gtg_cordic
// Pipelined vectoring CORDIC: bearing of the goal offset, one step a stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gtg_cordic import gtg_pkg::*; (
  input  logic                    clk,
  input  stage_en_t               stage_en,
  input  logic signed [OFS_W-1:0] dx,
  input  logic signed [OFS_W-1:0] dy,
  output logic signed [ZW-1:0]    z
);

  logic signed [XW-1:0] x_q [CORDIC_PRE:CORDIC_LAST-1];
  logic signed [XW-1:0] y_q [CORDIC_PRE:CORDIC_LAST-1];
  logic signed [ZW-1:0] z_q [CORDIC_PRE:CORE_LAST];

  logic signed [XW-1:0] x_ext;
  logic signed [XW-1:0] y_ext;

  assign x_ext = XW'(dx) <<< VEC_SHIFT;
  assign y_ext = XW'(dy) <<< VEC_SHIFT;

  // Fold the left half-plane over by a half turn
  always_ff @(posedge clk) begin
    if (stage_en[CORDIC_PRE]) begin
      if (dx < 0) begin
        x_q[CORDIC_PRE] <= -x_ext;
        y_q[CORDIC_PRE] <= -y_ext;
        z_q[CORDIC_PRE] <= (dy >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        x_q[CORDIC_PRE] <= x_ext;
        y_q[CORDIC_PRE] <= y_ext;
        z_q[CORDIC_PRE] <= '0;
      end
    end
  end

  for (genvar k = CORDIC_FIRST; k <= CORE_LAST; k++) begin : g_stage
    if (k <= CORDIC_LAST) begin : g_step
      localparam int I = k - CORDIC_FIRST;
      logic                 neg;

      assign neg = y_q[k-1][XW-1];

      // Rotate toward the x axis and accumulate the angle
      always_ff @(posedge clk) begin
        if (stage_en[k]) begin
          z_q[k] <= neg ? (z_q[k-1] - ATAN_TAB[I]) : (z_q[k-1] + ATAN_TAB[I]);
        end
      end

      if (k < CORDIC_LAST) begin : g_xy
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;

        assign xs = x_q[k-1] >>> I;
        assign ys = y_q[k-1] >>> I;

        always_ff @(posedge clk) begin
          if (stage_en[k]) begin
            x_q[k] <= neg ? (x_q[k-1] - ys) : (x_q[k-1] + ys);
            y_q[k] <= neg ? (y_q[k-1] + xs) : (y_q[k-1] - xs);
          end
        end
      end
    end else begin : g_hold
      // Carry the angle until the root is ready
      always_ff @(posedge clk) begin
        if (stage_en[k]) begin
          z_q[k] <= z_q[k-1];
        end
      end
    end
  end

  assign z = z_q[CORE_LAST];

endmodule

`default_nettype wire

FILE: src/gtg_isqrt.sv
// ---------------------------------------------------------------------------
// gtg_isqrt
// Pipelined restoring integer square root, one root bit a stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gtg_isqrt import gtg_pkg::*; (
  input  logic              clk,
  input  stage_en_t         stage_en,
  input  logic [SQ_W-1:0]   sq,
  output logic [DIST_W-1:0] root,
  output logic [DIST_W:0]   rem
);

  logic [SQ_W-1:0]   s_q [SQRT_FIRST:SQRT_LAST];
  logic [DIST_W-1:0] q_q [SQRT_FIRST:CORE_LAST];
  logic [DIST_W:0]   r_q [SQRT_FIRST:CORE_LAST];

  for (genvar k = SQRT_FIRST; k <= CORE_LAST; k++) begin : g_stage
    if (k <= SQRT_LAST) begin : g_step
      localparam int B = SQRT_LAST - k;
      logic [SQ_W-1:0]   s_in;
      logic [DIST_W-1:0] q_in;
      logic [DIST_W:0]   r_in;
      logic [DIST_W+2:0] r_try;
      logic [DIST_W+2:0] t_val;
      logic [DIST_W+2:0] r_diff;

      if (k == SQRT_FIRST) begin : g_head
        assign s_in = sq;
        assign q_in = '0;
        assign r_in = '0;
      end else begin : g_tail
        assign s_in = s_q[k-1];
        assign q_in = q_q[k-1];
        assign r_in = r_q[k-1];
      end

      // Bring down the next bit pair and try the trial divisor
      assign r_try  = {r_in, s_in[2*B+1 -: 2]};
      assign t_val  = {1'b0, q_in, 2'b01};
      assign r_diff = r_try - t_val;

      always_ff @(posedge clk) begin
        if (stage_en[k]) begin
          s_q[k] <= s_in;
          if (r_try >= t_val) begin
            r_q[k] <= r_diff[DIST_W:0];
            q_q[k] <= {q_in[DIST_W-2:0], 1'b1};
          end else begin
            r_q[k] <= r_try[DIST_W:0];
            q_q[k] <= {q_in[DIST_W-2:0], 1'b0};
          end
        end
      end
    end else begin : g_hold
      // Carry root and remainder until the bearing is ready
      always_ff @(posedge clk) begin
        if (stage_en[k]) begin
          q_q[k] <= q_q[k-1];
          r_q[k] <= r_q[k-1];
        end
      end
    end
  end

  assign root = q_q[CORE_LAST];
  assign rem  = r_q[CORE_LAST];

endmodule

`default_nettype wire

FILE: src/gtg_drive.sv
// ---------------------------------------------------------------------------
// gtg_drive
// Rounds distance and bearing, applies the gains, saturates the commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gtg_drive import gtg_pkg::*; (
  input  logic                     clk,
  input  stage_en_t                stage_en,
  input  cfg_t                     cfg,
  input  logic [DIST_W-1:0]        root,
  input  logic [DIST_W:0]          rem,
  input  logic signed [ZW-1:0]     z,
  input  logic signed [HEAD_W-1:0] heading,
  output logic [LIN_W-1:0]         linear_speed,
  output logic signed [ANG_W-1:0]  turn_rate,
  output logic [DIST_W-1:0]        goal_distance,
  output logic                     arrived
);

  localparam int HALF   = 1 << (FRAC_BITS - 1);
  localparam int Z_HALF = 1 << (ANG_SHIFT - 1);

  logic [DIST_W-1:0]        dist_a;
  logic signed [BEAR_W-1:0] bearing_a;
  logic signed [HEAD_W-1:0] head_a;
  logic signed [ZW-1:0]     z_round;

  logic [DIST_W-1:0]        dist_b;
  logic signed [ERR_W-1:0]  err_b;
  logic                     arrived_b;

  logic [LINP_W-1:0]        lin_c;
  logic signed [ANGP_W-1:0] ang_c;
  logic [DIST_W-1:0]        dist_c;
  logic                     arrived_c;

  logic [LINP_W:0]          lin_sum;
  logic [LINP_W:0]          lin_sh;
  logic signed [ANGP_W:0]   ang_sum;
  logic signed [ANGP_W:0]   ang_sh;
  logic [LIN_W-1:0]         lin_sat;
  logic signed [ANG_W-1:0]  ang_sat;

  assign z_round = z + ZW'(Z_HALF);

  // Round the root to nearest and the angle half up
  always_ff @(posedge clk) begin
    if (stage_en[DRV_ROUND]) begin
      dist_a    <= root + DIST_W'(rem > {1'b0, root});
      bearing_a <= BEAR_W'(z_round >>> ANG_SHIFT);
      head_a    <= heading;
    end
  end

  // Arrival test and heading error
  always_ff @(posedge clk) begin
    if (stage_en[DRV_ERR]) begin
      dist_b    <= dist_a;
      arrived_b <= dist_a <= cfg.arrive_tolerance;
      err_b     <= ERR_W'(bearing_a) - ERR_W'(head_a);
    end
  end

  // Gain products
  always_ff @(posedge clk) begin
    if (stage_en[DRV_MUL]) begin
      dist_c    <= dist_b;
      arrived_c <= arrived_b;
      lin_c     <= LINP_W'(cfg.kp) * LINP_W'(dist_b);
      ang_c     <= ANGP_W'($signed({1'b0, cfg.heading_gain})) * ANGP_W'(err_b);
    end
  end

  // Round and clamp the commands
  always_comb begin
    lin_sum = {1'b0, lin_c} + (LINP_W+1)'(HALF);
    lin_sh  = lin_sum >> FRAC_BITS;
    ang_sum = (ANGP_W+1)'(ang_c) + (ANGP_W+1)'(HALF);
    ang_sh  = ang_sum >>> FRAC_BITS;
    if (lin_sh > (LINP_W+1)'(LIN_MAX)) begin
      lin_sat = LIN_MAX;
    end else begin
      lin_sat = lin_sh[LIN_W-1:0];
    end
    if (ang_sh > (ANGP_W+1)'(ANG_MAX)) begin
      ang_sat = ANG_MAX;
    end else if (ang_sh < (ANGP_W+1)'(ANG_MIN)) begin
      ang_sat = ANG_MIN;
    end else begin
      ang_sat = ang_sh[ANG_W-1:0];
    end
  end

  // Output register: zero the commands once the goal is reached
  always_ff @(posedge clk) begin
    if (stage_en[OUT_STAGE]) begin
      linear_speed  <= arrived_c ? '0 : lin_sat;
      turn_rate     <= arrived_c ? '0 : ang_sat;
      goal_distance <= dist_c;
      arrived       <= arrived_c;
    end
  end

endmodule

`default_nettype wire

FILE: src/go_to_goal_controller.sv
// ---------------------------------------------------------------------------
// go_to_goal_controller
// Proportional go-to-goal drive command from a measured pose sample.
// ---------------------------------------------------------------------------
// One pose sample is taken per cycle while the output side is ready,
// and every sample yields one command, in order. The pipeline is 24 register
// stages deep; a command leaves the last stage on the next edge at which the
// output side is ready. The depth is set by the 17-stage square root (one
// root bit per stage) that runs beside the 16-stage CORDIC, plus offset,
// square, sum, rounding, heading error, gain and saturation stages.
// Each stage holds its own valid bit, so a stalled output only holds the
// stages that carry data and bubbles keep closing up behind it. Goal,
// tolerance and gains are written through the cfg channel, which is always
// ready; write it only while no sample is in flight. The heading error is
// the raw difference bearing minus heading with no angle wrap.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module go_to_goal_controller import gtg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // pose_x[15:0], pose_y[31:16], pose_heading[47:32]
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_W-1:0]       s_axis_tdata,
  // linear_speed[19:0], turn_rate[37:20], goal_distance[54:38], arrived[55]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                     cfg;
  logic [N_STAGES-1:0]      vld;
  stage_en_t                stage_en;

  logic [POS_W-1:0]         pose_x;
  logic [POS_W-1:0]         pose_y;
  logic signed [HEAD_W-1:0] pose_heading;

  logic signed [OFS_W-1:0]  dx0;
  logic signed [OFS_W-1:0]  dy0;
  logic [POS_W-1:0]         adx0;
  logic [POS_W-1:0]         ady0;
  logic [SQ_W-1:0]          dx_sq;
  logic [SQ_W-1:0]          dy_sq;
  logic [SQ_W-1:0]          sq;
  logic signed [HEAD_W-1:0] hd [0:CORE_LAST];

  logic signed [ZW-1:0]     z_core;
  logic [DIST_W-1:0]        root_core;
  logic [DIST_W:0]          rem_core;

  logic [LIN_W-1:0]         linear_speed;
  logic signed [ANG_W-1:0]  turn_rate;
  logic [DIST_W-1:0]        goal_distance;
  logic                     arrived;

  assign pose_x       = s_axis_tdata[POS_W-1:0];
  assign pose_y       = s_axis_tdata[2*POS_W-1:POS_W];
  assign pose_heading = s_axis_tdata[IN_W-1:2*POS_W];

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_GOAL_X:       cfg.goal_x           <= cfg_data[POS_W-1:0];
        REG_GOAL_Y:       cfg.goal_y           <= cfg_data[POS_W-1:0];
        REG_ARRIVE_TOL:   cfg.arrive_tolerance <= cfg_data[TOL_W-1:0];
        REG_KP:           cfg.kp               <= cfg_data[GAIN_W-1:0];
        REG_HEADING_GAIN: cfg.heading_gain     <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when empty or when the next one loads
  assign stage_en[N_STAGES-1] = !vld[N_STAGES-1] || m_axis_tready;
  for (genvar k = 0; k < N_STAGES - 1; k++) begin : g_en
    assign stage_en[k] = !vld[k] || stage_en[k+1];
  end

  assign s_axis_tready = stage_en[0];
  assign m_axis_tvalid = vld[N_STAGES-1];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (stage_en[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < N_STAGES; k++) begin
        if (stage_en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Goal offset, signed and as magnitude
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      dx0  <= $signed({1'b0, cfg.goal_x}) - $signed({1'b0, pose_x});
      dy0  <= $signed({1'b0, cfg.goal_y}) - $signed({1'b0, pose_y});
      adx0 <= (cfg.goal_x >= pose_x) ? (cfg.goal_x - pose_x) : (pose_x - cfg.goal_x);
      ady0 <= (cfg.goal_y >= pose_y) ? (cfg.goal_y - pose_y) : (pose_y - cfg.goal_y);
    end
  end

  // Squares, then their sum
  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      dx_sq <= SQ_W'((2*POS_W)'(adx0) * (2*POS_W)'(adx0));
      dy_sq <= SQ_W'((2*POS_W)'(ady0) * (2*POS_W)'(ady0));
    end
    if (stage_en[2]) begin
      sq <= dx_sq + dy_sq;
    end
  end

  // Carry heading alongside the core
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      hd[0] <= pose_heading;
    end
    for (int k = 1; k <= CORE_LAST; k++) begin
      if (stage_en[k]) begin
        hd[k] <= hd[k-1];
      end
    end
  end

  gtg_cordic u_cordic (
    .clk      (clk),
    .stage_en (stage_en),
    .dx       (dx0),
    .dy       (dy0),
    .z        (z_core)
  );

  gtg_isqrt u_isqrt (
    .clk      (clk),
    .stage_en (stage_en),
    .sq       (sq),
    .root     (root_core),
    .rem      (rem_core)
  );

  gtg_drive u_drive (
    .clk           (clk),
    .stage_en      (stage_en),
    .cfg           (cfg),
    .root          (root_core),
    .rem           (rem_core),
    .z             (z_core),
    .heading       (hd[CORE_LAST]),
    .linear_speed  (linear_speed),
    .turn_rate     (turn_rate),
    .goal_distance (goal_distance),
    .arrived       (arrived)
  );

  assign m_axis_tdata = {arrived, goal_distance, turn_rate, linear_speed};

endmodule

`default_nettype wire

FILE: src/gtg_checker.sv
// ---------------------------------------------------------------------------
// gtg_checker
// Port-level checks for the go-to-goal controller, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gtg_checker import gtg_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Arrival forces both speed commands to zero
  a_arrive_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[55] |-> m_axis_tdata[37:0] == 38'd0)
    else $error("nonzero speed on arrival");

  // Not arrived means the distance is above a nonnegative tolerance
  a_dist_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[55] |-> m_axis_tdata[54:38] != 17'd0)
    else $error("zero distance without arrival");

  // An open output lets the whole pipeline advance
  a_flow: assert property (@(posedge clk)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is ready");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result presented after reset");

endmodule

bind go_to_goal_controller gtg_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
